// ===== sv/msgs_pkg.sv =====
package msgs_pkg;

  // Stop table depth default
  localparam int unsigned MAX_STOPS = 8;

  // Configuration port
  localparam int unsigned CFG_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

  // Function codes of an input word
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  // Q1.16 constants
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] SCALE_OPAQUE = 17'd65471;
  localparam logic [24:0] ROUND_HALF   = 25'd32768;

  // Iteration counts of the two dividers
  localparam int unsigned T_STEPS = 16;
  localparam int unsigned B_STEPS = 8;
  localparam int unsigned STEP_W  = 4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_T_INIT,
    OP_T_STEP,
    OP_CHK_LAST,
    OP_SEL_ZERO,
    OP_SEL_RD,
    OP_SEL_LAST,
    OP_SAVE_PREV,
    OP_MUL,
    OP_B_STEP,
    OP_SEL_BLEND,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic t_le_pos;   // t <= offset of the entry just read
    logic hit_last;   // t >= offset of the last stop
    logic out_free;   // output register can take a word
  } dp_stat_t;

endpackage

// ===== sv/msgs_ctrl.sv =====
module msgs_ctrl #(
  parameter int unsigned MAX_STOPS = msgs_pkg::MAX_STOPS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [1:0]                   func_i,
  output logic                         in_stall_o,
  input  logic [$clog2(MAX_STOPS)-1:0] last_addr_i,
  input  msgs_pkg::dp_stat_t           stat_i,
  output msgs_pkg::dp_cmd_t            cmd_o,
  output logic [$clog2(MAX_STOPS)-1:0] rd_addr_o
);

  localparam int unsigned AW = $clog2(MAX_STOPS);
  localparam int unsigned SW = msgs_pkg::STEP_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDIV,
    ST_CHK_LAST,
    ST_CHK_FIRST,
    ST_SCAN,
    ST_BDIV,
    ST_SEL,
    ST_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [SW-1:0] step_q, step_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer: one sample at a time, clear and append finish on acceptance
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    step_d    = step_q;
    cmd_o.op  = msgs_pkg::OP_NONE;
    rd_addr_o = last_addr_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            msgs_pkg::FUNC_CLEAR:  cmd_o.op = msgs_pkg::OP_CLEAR;
            msgs_pkg::FUNC_APPEND: cmd_o.op = msgs_pkg::OP_APPEND;
            msgs_pkg::FUNC_SAMPLE: begin
              if (stat_i.count_zero) begin
                cmd_o.op = msgs_pkg::OP_SEL_ZERO;
                state_d  = ST_OUT;
              end else begin
                cmd_o.op = msgs_pkg::OP_T_INIT;
                step_d   = '0;
                state_d  = ST_TDIV;
              end
            end
            default: ;
          endcase
        end
      end
      // t divider runs while the last stop is fetched
      ST_TDIV: begin
        cmd_o.op = msgs_pkg::OP_T_STEP;
        if (step_q == SW'(msgs_pkg::T_STEPS - 1)) begin
          state_d = ST_CHK_LAST;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      ST_CHK_LAST: begin
        cmd_o.op  = msgs_pkg::OP_CHK_LAST;
        rd_addr_o = '0;
        state_d   = ST_CHK_FIRST;
      end
      ST_CHK_FIRST: begin
        rd_addr_o = AW'(1);
        if (stat_i.count_one || stat_i.t_le_pos) begin
          cmd_o.op = msgs_pkg::OP_SEL_RD;
          state_d  = ST_OUT;
        end else if (stat_i.hit_last) begin
          cmd_o.op = msgs_pkg::OP_SEL_LAST;
          state_d  = ST_OUT;
        end else begin
          cmd_o.op = msgs_pkg::OP_SAVE_PREV;
          idx_d    = AW'(1);
          state_d  = ST_SCAN;
        end
      end
      // walk the table for the first stop at or past t
      ST_SCAN: begin
        rd_addr_o = idx_q + AW'(1);
        if (stat_i.t_le_pos || (idx_q == last_addr_i)) begin
          cmd_o.op = msgs_pkg::OP_MUL;
          step_d   = '0;
          state_d  = ST_BDIV;
        end else begin
          cmd_o.op = msgs_pkg::OP_SAVE_PREV;
          idx_d    = idx_q + AW'(1);
        end
      end
      ST_BDIV: begin
        cmd_o.op = msgs_pkg::OP_B_STEP;
        if (step_q == SW'(msgs_pkg::B_STEPS - 1)) begin
          state_d = ST_SEL;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      ST_SEL: begin
        cmd_o.op = msgs_pkg::OP_SEL_BLEND;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = msgs_pkg::OP_LOAD_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== sv/msgs_dp.sv =====
module msgs_dp #(
  parameter int unsigned MAX_STOPS = msgs_pkg::MAX_STOPS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [msgs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [16:0]                    stop_offset_i,
  input  logic [31:0]                    stop_color_i,
  input  logic signed [15:0]             sample_y_i,
  input  msgs_pkg::dp_cmd_t              cmd_i,
  input  logic [$clog2(MAX_STOPS)-1:0]   rd_addr_i,
  output msgs_pkg::dp_stat_t             stat_o,
  output logic [$clog2(MAX_STOPS)-1:0]   last_addr_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     opacity_o
);

  localparam int unsigned AW = $clog2(MAX_STOPS);
  localparam int unsigned CW = $clog2(MAX_STOPS + 1);

  typedef enum logic [1:0] {
    T_ZERO,
    T_ONE,
    T_DIV
  } t_mode_e;

  // Configuration registers
  logic signed [15:0] start_q, end_q;
  logic [16:0]        scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      scale_q <= msgs_pkg::ONE_Q16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msgs_pkg::CFG_START: start_q <= cfg_data_i[15:0];
        msgs_pkg::CFG_END:   end_q   <= cfg_data_i[15:0];
        msgs_pkg::CFG_SCALE: scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stop table: {offset, color} per entry, registered read
  logic [48:0]   mem_q [MAX_STOPS];
  logic [48:0]   rd_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] cnt_m1;
  logic          full;
  logic [16:0]   off_sat;

  assign full    = (count_q == CW'(MAX_STOPS));
  assign off_sat = (stop_offset_i > msgs_pkg::ONE_Q16) ? msgs_pkg::ONE_Q16 : stop_offset_i;
  assign cnt_m1  = count_q - CW'(1);
  assign last_addr_o = cnt_m1[AW-1:0];

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == msgs_pkg::OP_APPEND) && !full) begin
      mem_q[count_q[AW-1:0]] <= {off_sat, stop_color_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.op == msgs_pkg::OP_CLEAR) begin
      count_q <= '0;
    end else if ((cmd_i.op == msgs_pkg::OP_APPEND) && !full) begin
      count_q <= count_q + CW'(1);
    end
  end

  logic [16:0] rd_pos;
  logic [31:0] rd_col;
  assign rd_pos = rd_q[48:32];
  assign rd_col = rd_q[31:0];

  // Gradient parameter t: restoring divider, one quotient bit per step
  logic signed [16:0] n_raw, s_raw, n_abs, s_abs;
  t_mode_e            mode_d;
  t_mode_e            mode_q;
  logic [16:0]        t_rem_q, t_r2;
  logic [15:0]        t_quo_q, s_q;
  logic [16:0]        t_val;

  always_comb begin
    n_raw = $signed({sample_y_i[15], sample_y_i}) - $signed({start_q[15], start_q});
    s_raw = $signed({end_q[15], end_q}) - $signed({start_q[15], start_q});
    n_abs = s_raw[16] ? -n_raw : n_raw;
    s_abs = s_raw[16] ? -s_raw : s_raw;
    if ((s_abs == '0) || n_abs[16] || (n_abs == '0)) begin
      mode_d = T_ZERO;
    end else if (n_abs[15:0] >= s_abs[15:0]) begin
      mode_d = T_ONE;
    end else begin
      mode_d = T_DIV;
    end
  end

  assign t_r2 = {t_rem_q[15:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == msgs_pkg::OP_T_INIT) begin
      mode_q  <= mode_d;
      t_rem_q <= {1'b0, n_abs[15:0]};
      s_q     <= s_abs[15:0];
      t_quo_q <= '0;
    end else if (cmd_i.op == msgs_pkg::OP_T_STEP) begin
      if (t_r2 >= {1'b0, s_q}) begin
        t_rem_q <= t_r2 - {1'b0, s_q};
        t_quo_q <= {t_quo_q[14:0], 1'b1};
      end else begin
        t_rem_q <= t_r2;
        t_quo_q <= {t_quo_q[14:0], 1'b0};
      end
    end
  end

  always_comb begin
    case (mode_q)
      T_ZERO:  t_val = '0;
      T_ONE:   t_val = msgs_pkg::ONE_Q16;
      T_DIV:   t_val = {1'b0, t_quo_q};
      default: t_val = '0;
    endcase
  end

  // Bracketing stops
  logic        hit_last_q;
  logic [31:0] last_col_q;
  logic [48:0] prev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == msgs_pkg::OP_CHK_LAST) begin
      hit_last_q <= (t_val >= rd_pos);
      last_col_q <= rd_col;
    end
    if (cmd_i.op == msgs_pkg::OP_SAVE_PREV) begin
      prev_q <= rd_q;
    end
  end

  // Blend: num = a*(d-u) + b*u, then four 8-bit quotient lanes over d
  logic [16:0] d_w, u_w, dmu_w;
  logic [23:0] num_d [4];
  logic [23:0] num_q [4];
  logic [7:0]  bq_q  [4];
  logic [23:0] dsh_q;
  logic [7:0]  ca, cb;

  assign d_w   = rd_pos - prev_q[48:32];
  assign u_w   = t_val - prev_q[48:32];
  assign dmu_w = rd_pos - t_val;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ca = prev_q[8*c +: 8];
      cb = rd_col[8*c +: 8];
      num_d[c] = ({16'd0, ca} * {7'd0, dmu_w}) + ({16'd0, cb} * {7'd0, u_w});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == msgs_pkg::OP_MUL) begin
      for (int c = 0; c < 4; c++) begin
        num_q[c] <= num_d[c];
        bq_q[c]  <= '0;
      end
      dsh_q <= {d_w, 7'd0};
    end else if (cmd_i.op == msgs_pkg::OP_B_STEP) begin
      for (int c = 0; c < 4; c++) begin
        if (num_q[c] >= dsh_q) begin
          num_q[c] <= num_q[c] - dsh_q;
          bq_q[c]  <= {bq_q[c][6:0], 1'b1};
        end else begin
          bq_q[c]  <= {bq_q[c][6:0], 1'b0};
        end
      end
      dsh_q <= {1'b0, dsh_q[23:1]};
    end
  end

  // Selected color before opacity scaling
  logic [31:0] col_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      msgs_pkg::OP_SEL_ZERO:  col_q <= '0;
      msgs_pkg::OP_SEL_RD:    col_q <= rd_col;
      msgs_pkg::OP_SEL_LAST:  col_q <= last_col_q;
      msgs_pkg::OP_SEL_BLEND: col_q <= {bq_q[3], bq_q[2], bq_q[1], bq_q[0]};
      default: ;
    endcase
  end

  // Opacity scaling, rounded half up; unscaled once scale reaches SCALE_OPAQUE
  logic [24:0] tint_prod;
  logic [7:0]  opa_d;

  always_comb begin
    tint_prod = ({17'd0, col_q[31:24]} * {8'd0, scale_q}) + msgs_pkg::ROUND_HALF;
    opa_d     = (scale_q >= msgs_pkg::SCALE_OPAQUE) ? col_q[31:24] : tint_prod[23:16];
  end

  // Output register
  logic out_valid_q;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == msgs_pkg::OP_LOAD_OUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == msgs_pkg::OP_LOAD_OUT) begin
      red_o     <= col_q[7:0];
      green_o   <= col_q[15:8];
      blue_o    <= col_q[23:16];
      opacity_o <= opa_d;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat_o.count_zero = (count_q == '0);
    stat_o.count_one  = (count_q == CW'(1));
    stat_o.t_le_pos   = (t_val <= rd_pos);
    stat_o.hit_last   = hit_last_q;
    stat_o.out_free   = out_free;
  end

endmodule

// ===== sv/multi_stop_gradient_sampler.sv =====
// Vertical multi-stop gradient sampler. Each input word either clears the stop
// table (func 0), appends a stop (func 1, dropped once MAX_STOPS stops are
// held, offsets above 1.0 saturate), or samples RGBA at sample_y (func 2);
// only a sample returns an output word. Clear and append finish as the word is
// taken. For a sample on a non-empty table, a 16-step divider forms t, the stop
// memory is then read one entry per cycle, and an interpolated result runs an
// 8-step divider. The block takes one word at a time; a finished result sits
// in the output register while the next word is taken. Write gradient_start,
// gradient_end and alpha_scale only while the block is idle.
module multi_stop_gradient_sampler #(
  parameter int unsigned MAX_STOPS = msgs_pkg::MAX_STOPS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [msgs_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [16:0]                    stop_offset_i,
  input  logic [31:0]                    stop_color_i,
  input  logic signed [15:0]             sample_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     opacity_o
);

  msgs_pkg::dp_cmd_t            cmd;
  msgs_pkg::dp_stat_t           stat;
  logic [$clog2(MAX_STOPS)-1:0] rd_addr;
  logic [$clog2(MAX_STOPS)-1:0] last_addr;

  msgs_ctrl #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .in_stall_o  (in_stall_o),
    .last_addr_i (last_addr),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  msgs_dp #(
    .MAX_STOPS (MAX_STOPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .stop_offset_i (stop_offset_i),
    .stop_color_i  (stop_color_i),
    .sample_y_i    (sample_y_i),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .stat_o        (stat),
    .last_addr_o   (last_addr),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .opacity_o     (opacity_o)
  );

endmodule
